### rtl/core/rmswd_pkg.sv
// Shared constants and types of the windowed RMS downsampler.
// Used by the channel interfaces, the front, queue and back modules and the top level.
// No dependencies.
package rmswd_pkg;

  // Port field widths
  localparam int unsigned SampleW     = 16;
  localparam int unsigned PointIdxW   = 9;
  localparam int unsigned LevelW      = 16;
  localparam int unsigned FrameCountW = 25;
  localparam int unsigned ChanCountW  = 4;
  localparam int unsigned CfgDataW    = 25;
  localparam int unsigned CfgAddrW    = 1;

  // Datapath widths
  localparam int unsigned MagW     = 17;  // |sample| reaches 32768
  localparam int unsigned SquareW  = 31;  // square reaches 2^30
  localparam int unsigned MeanW    = 31;  // mean square reaches 2^30
  localparam int unsigned RootW    = 16;
  localparam int unsigned SremW    = 18;  // square root partial remainder
  localparam int unsigned StepCntW = 5;

  localparam logic [StepCntW-1:0] DivLastStep  = StepCntW'(MeanW - 1);
  localparam logic [StepCntW-1:0] SqrtLastStep = StepCntW'(RootW - 1);

  // Defaults and limits
  localparam int unsigned DefaultPoints      = 512;
  localparam int unsigned DefaultMaxChannels = 8;
  localparam int unsigned MaxFrames          = 16777216;
  localparam int unsigned QueueDepth         = 2;

  localparam logic [FrameCountW-1:0] FrameCountReset = FrameCountW'(512);
  localparam logic [ChanCountW-1:0]  ChanCountReset  = ChanCountW'(1);
  localparam logic [LevelW-1:0]      MaxLevel        = LevelW'(32768);

  // Configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    REG_FRAME_COUNT   = 1'b0,
    REG_CHANNEL_COUNT = 1'b1
  } cfg_reg_e;

  // Back end sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SQRT,
    BK_OUT
  } back_state_e;

endpackage

### rtl/core/rmswd_if.sv
// Valid/ready channel interfaces of the windowed RMS downsampler.
// Depends on rmswd_pkg for the payload widths.
interface rmswd_sample_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [rmswd_pkg::SampleW-1:0]   sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface rmswd_point_if;
  logic                               valid;
  logic                               ready;
  logic [rmswd_pkg::PointIdxW-1:0]    point_index;
  logic [rmswd_pkg::LevelW-1:0]       rms_level;
  logic                               last_point;

  modport source (output valid, output point_index, output rms_level, output last_point,
                  input ready);
  modport sink   (input valid, input point_index, input rms_level, input last_point,
                  output ready);
endinterface

### rtl/core/rmswd_front.sv
// Front end: configuration registers, sample squaring and window accumulation.
// Pushes one job (index, last flag, square sum, sample count) per closed window.
// Depends on rmswd_pkg.
module rmswd_front #(
  parameter int unsigned Points      = rmswd_pkg::DefaultPoints,
  parameter int unsigned MaxChannels = rmswd_pkg::DefaultMaxChannels,
  parameter int unsigned JobW        = 1
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [rmswd_pkg::CfgAddrW-1:0]        cfg_addr_i,
  input  logic [rmswd_pkg::CfgDataW-1:0]        cfg_wdata_i,
  input  logic                                  sample_valid_i,
  input  logic signed [rmswd_pkg::SampleW-1:0]  sample_i,
  output logic                                  sample_ready_o,
  output logic                                  job_valid_o,
  input  logic                                  job_ready_i,
  output logic [JobW-1:0]                       job_o
);
  import rmswd_pkg::*;

  localparam int unsigned WinW    = $clog2(Points);
  localparam int unsigned ChW     = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
  localparam int unsigned AccW    = FrameCountW + WinW + 1;
  localparam int unsigned TallyW  = $clog2((MaxFrames / Points + 1) * MaxChannels + 1);
  localparam int unsigned SumW    = TallyW + SquareW - 1;
  localparam int unsigned IdxExtW = (WinW > PointIdxW) ? WinW : PointIdxW;

  localparam logic [FrameCountW-1:0] PointsF    = FrameCountW'(Points);
  localparam logic [FrameCountW-1:0] MaxFramesF = FrameCountW'(MaxFrames);
  localparam logic [ChanCountW:0]    MaxChanC   = (ChanCountW + 1)'(MaxChannels);
  localparam logic [AccW-1:0]        PointsAcc  = AccW'(Points);
  localparam logic [WinW-1:0]        LastWin    = WinW'(Points - 1);

  typedef struct packed {
    logic [PointIdxW-1:0] idx;
    logic                 last;
    logic [SumW-1:0]      sum;
    logic [TallyW-1:0]    tally;
  } job_t;

  logic [FrameCountW-1:0] frame_count_q;
  logic [ChanCountW-1:0]  chan_count_q;
  logic                   restart_q;
  logic [ChW-1:0]         chan_pos_q;
  logic [WinW-1:0]        win_q;
  logic [AccW-1:0]        frame_acc_q;  // (frame position + 1) * Points
  logic [AccW-1:0]        bound_acc_q;  // (window number + 1) * frames
  logic [SumW-1:0]        sum_q;
  logic [TallyW-1:0]      tally_q;

  logic [FrameCountW-1:0] n_eff;
  logic [ChanCountW:0]    chan_ext;
  logic [ChanCountW:0]    last_ch;
  logic signed [MagW-1:0] sample_ext;
  logic [MagW-1:0]        mag;
  logic [2*MagW-1:0]      sq_full;
  logic [SquareW-1:0]     sq;
  logic [SumW-1:0]        sum_new;
  logic [TallyW-1:0]      tally_new;
  logic [AccW-1:0]        frame_next;
  logic                   frame_end;
  logic                   win_end;
  logic                   win_last;
  logic                   in_fire;
  logic [IdxExtW-1:0]     idx_ext;
  job_t                   job;

  // Clamp the configured frame and channel counts
  always_comb begin
    if (frame_count_q < PointsF) begin
      n_eff = PointsF;
    end else if (frame_count_q > MaxFramesF) begin
      n_eff = MaxFramesF;
    end else begin
      n_eff = frame_count_q;
    end
    chan_ext = {1'b0, chan_count_q};
    if (chan_count_q == '0) begin
      last_ch = '0;
    end else if (chan_ext > MaxChanC) begin
      last_ch = MaxChanC - 1'b1;
    end else begin
      last_ch = chan_ext - 1'b1;
    end
  end

  // Square the sample and find window boundaries
  always_comb begin
    sample_ext = MagW'(sample_i);
    mag        = sample_i[SampleW-1] ? MagW'(-sample_ext) : MagW'(sample_ext);
    sq_full    = mag * mag;
    sq         = sq_full[SquareW-1:0];
    sum_new    = sum_q + SumW'(sq);
    tally_new  = tally_q + TallyW'(1);
    frame_next = frame_acc_q + PointsAcc;
    frame_end  = ((ChanCountW + 1)'(chan_pos_q) == last_ch);
    win_end    = frame_end && (frame_next > bound_acc_q);
    win_last   = (win_q == LastWin);
    idx_ext    = IdxExtW'(win_q);
  end

  assign sample_ready_o = !restart_q && job_ready_i;
  assign in_fire        = sample_valid_i && sample_ready_o;

  always_comb begin
    job.idx   = idx_ext[PointIdxW-1:0];
    job.last  = win_last;
    job.sum   = sum_new;
    job.tally = tally_new;
  end

  assign job_valid_o = in_fire && win_end;
  assign job_o       = JobW'(job);

  // Configuration registers; any write restarts the buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= FrameCountReset;
      chan_count_q  <= ChanCountReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_FRAME_COUNT:   frame_count_q <= cfg_wdata_i[FrameCountW-1:0];
        REG_CHANNEL_COUNT: chan_count_q  <= cfg_wdata_i[ChanCountW-1:0];
        default: ;
      endcase
    end
  end

  // Advance channel, frame and window positions; accumulate squares
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_q   <= 1'b1;
      chan_pos_q  <= '0;
      win_q       <= '0;
      frame_acc_q <= '0;
      bound_acc_q <= '0;
      sum_q       <= '0;
      tally_q     <= '0;
    end else if (cfg_we_i) begin
      restart_q <= 1'b1;
    end else if (restart_q) begin
      restart_q   <= 1'b0;
      chan_pos_q  <= '0;
      win_q       <= '0;
      frame_acc_q <= PointsAcc;
      bound_acc_q <= AccW'(n_eff);
      sum_q       <= '0;
      tally_q     <= '0;
    end else if (in_fire) begin
      if (!frame_end) begin
        chan_pos_q <= chan_pos_q + ChW'(1);
        sum_q      <= sum_new;
        tally_q    <= tally_new;
      end else if (!win_end) begin
        chan_pos_q  <= '0;
        frame_acc_q <= frame_next;
        sum_q       <= sum_new;
        tally_q     <= tally_new;
      end else begin
        chan_pos_q <= '0;
        sum_q      <= '0;
        tally_q    <= '0;
        if (win_last) begin
          win_q       <= '0;
          frame_acc_q <= PointsAcc;
          bound_acc_q <= AccW'(n_eff);
        end else begin
          win_q       <= win_q + WinW'(1);
          frame_acc_q <= frame_next;
          bound_acc_q <= bound_acc_q + AccW'(n_eff);
        end
      end
    end
  end

endmodule

### rtl/core/rmswd_fifo.sv
// Short job queue between the front and back ends of the downsampler.
// Depends on rmswd_pkg for the default depth.
module rmswd_fifo #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = rmswd_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);
  import rmswd_pkg::*;

  localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [AW-1:0]   LastAddr = AW'(Depth - 1);
  localparam logic [CntW-1:0] Full     = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_ptr_q;
  logic [AW-1:0]    rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             push;
  logic             pop;

  assign push_ready_o = (count_q != Full);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Store pushed words
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + AW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

### rtl/core/rmswd_back.sv
// Back end: divides a window's square sum by its sample count, one quotient bit
// per cycle, then takes the integer square root, one root bit per cycle.
// Depends on rmswd_pkg.
module rmswd_back #(
  parameter int unsigned Points      = rmswd_pkg::DefaultPoints,
  parameter int unsigned MaxChannels = rmswd_pkg::DefaultMaxChannels,
  parameter int unsigned JobW        = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             job_valid_i,
  output logic                             job_ready_o,
  input  logic [JobW-1:0]                  job_i,
  output logic                             point_valid_o,
  input  logic                             point_ready_i,
  output logic [rmswd_pkg::PointIdxW-1:0]  point_index_o,
  output logic [rmswd_pkg::LevelW-1:0]     rms_level_o,
  output logic                             last_point_o
);
  import rmswd_pkg::*;

  localparam int unsigned TallyW = $clog2((MaxFrames / Points + 1) * MaxChannels + 1);
  localparam int unsigned SumW   = TallyW + SquareW - 1;
  localparam int unsigned RadW   = 2 * RootW;

  typedef struct packed {
    logic [PointIdxW-1:0] idx;
    logic                 last;
    logic [SumW-1:0]      sum;
    logic [TallyW-1:0]    tally;
  } job_t;

  back_state_e state_q;
  back_state_e state_d;

  job_t                  job;
  logic [PointIdxW-1:0]  idx_q;
  logic                  last_q;
  logic [TallyW-1:0]     divisor_q;
  logic [TallyW-1:0]     drem_q;
  logic [MeanW-1:0]      dq_q;     // dividend bits out, quotient bits in
  logic [StepCntW-1:0]   step_q;
  logic [SremW-1:0]      srem_q;
  logic [RootW-1:0]      root_q;
  logic [RadW-1:0]       rad_q;
  logic [LevelW-1:0]     level_q;

  logic [TallyW:0]       div_shift;
  logic [TallyW:0]       div_diff;
  logic                  div_ge;
  logic [TallyW-1:0]     drem_next;
  logic [MeanW-1:0]      dq_next;
  logic [SremW+1:0]      sq_shift;
  logic [SremW+1:0]      sq_trial;
  logic [SremW+1:0]      sq_diff;
  logic                  sq_ge;
  logic [SremW-1:0]      srem_next;
  logic [RootW-1:0]      root_next;
  logic                  job_take;

  assign job = job_t'(job_i);

  // One restoring division step
  always_comb begin
    div_shift = {drem_q, dq_q[MeanW-1]};
    div_diff  = div_shift - {1'b0, divisor_q};
    div_ge    = (div_shift >= {1'b0, divisor_q});
    drem_next = div_ge ? div_diff[TallyW-1:0] : div_shift[TallyW-1:0];
    dq_next   = {dq_q[MeanW-2:0], div_ge};
  end

  // One square root step over two radicand bits
  always_comb begin
    sq_shift  = {srem_q, rad_q[RadW-1 -: 2]};
    sq_trial  = (SremW + 2)'({root_q, 2'b01});
    sq_diff   = sq_shift - sq_trial;
    sq_ge     = (sq_shift >= sq_trial);
    srem_next = sq_ge ? sq_diff[SremW-1:0] : sq_shift[SremW-1:0];
    root_next = {root_q[RootW-2:0], sq_ge};
  end

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and handshakes
  always_comb begin
    state_d       = state_q;
    job_take      = 1'b0;
    point_valid_o = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        job_take = job_valid_i;
        if (job_valid_i) begin
          state_d = BK_DIV;
        end
      end
      BK_DIV: begin
        if (step_q == DivLastStep) begin
          state_d = BK_SQRT;
        end
      end
      BK_SQRT: begin
        if (step_q == SqrtLastStep) begin
          state_d = BK_OUT;
        end
      end
      BK_OUT: begin
        point_valid_o = 1'b1;
        if (point_ready_i) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  assign job_ready_o = job_take;

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          idx_q     <= job.idx;
          last_q    <= job.last;
          divisor_q <= job.tally;
          drem_q    <= TallyW'(job.sum[SumW-1:MeanW]);
          dq_q      <= job.sum[MeanW-1:0];
          step_q    <= '0;
        end
      end
      BK_DIV: begin
        drem_q <= drem_next;
        dq_q   <= dq_next;
        if (step_q == DivLastStep) begin
          rad_q  <= RadW'(dq_next);
          srem_q <= '0;
          root_q <= '0;
          step_q <= '0;
        end else begin
          step_q <= step_q + StepCntW'(1);
        end
      end
      BK_SQRT: begin
        srem_q <= srem_next;
        root_q <= root_next;
        rad_q  <= {rad_q[RadW-3:0], 2'b00};
        step_q <= step_q + StepCntW'(1);
        if (step_q == SqrtLastStep) begin
          level_q <= LevelW'(root_next);
        end
      end
      default: ;
    endcase
  end

  assign point_index_o = idx_q;
  assign rms_level_o   = level_q;
  assign last_point_o  = last_q;

endmodule

### rtl/core/rms_window_downsampler_unit.sv
// Top level of the windowed RMS downsampler: front end, job queue and back end.
// Depends on rmswd_pkg, rmswd_if, rmswd_front, rmswd_fifo and rmswd_back.
//
// Usage:
//   in_i  carries interleaved Q1.15 samples, channel 0 first in each frame.
//   out_o carries one display point per window: index, RMS level, last flag.
//   cfg_*  writes frame_count (index 0) and channel_count (index 1); write
//          only while no window is in flight. Any write restarts at window 0.
// Throughput:
//   The front takes one sample per cycle unless stalled and closes a window in the
//   cycle of its last sample. The back end loads a window, runs the bit-serial
//   divide of square sum by sample count, then the bit-serial square root, and
//   presents the point; it takes no new window until that point is accepted.
//   A two-entry queue holds closed windows; when windows close faster than the
//   back end finishes them, the front stalls on a full queue.
// Reset and configuration: in_i.ready stays low for one cycle after reset
//   and after each configuration write while the window bounds reload.
// Stalls: a stalled out_o holds its point; the back end waits, the queue
//   fills, then in_i.ready drops.
module rms_window_downsampler_unit #(
  parameter int unsigned Points      = rmswd_pkg::DefaultPoints,
  parameter int unsigned MaxChannels = rmswd_pkg::DefaultMaxChannels
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rmswd_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [rmswd_pkg::CfgDataW-1:0] cfg_wdata_i,
  rmswd_sample_if.sink                   in_i,
  rmswd_point_if.source                  out_o
);
  import rmswd_pkg::*;

  localparam int unsigned TallyW = $clog2((MaxFrames / Points + 1) * MaxChannels + 1);
  localparam int unsigned SumW   = TallyW + SquareW - 1;
  localparam int unsigned JobW   = PointIdxW + 1 + SumW + TallyW;

  logic            push_valid;
  logic            push_ready;
  logic [JobW-1:0] push_data;
  logic            pop_valid;
  logic            pop_ready;
  logic [JobW-1:0] pop_data;

  // Accept samples and close windows
  rmswd_front #(
    .Points      (Points),
    .MaxChannels (MaxChannels),
    .JobW        (JobW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .sample_valid_i (in_i.valid),
    .sample_i       (in_i.sample),
    .sample_ready_o (in_i.ready),
    .job_valid_o    (push_valid),
    .job_ready_i    (push_ready),
    .job_o          (push_data)
  );

  // Hold closed windows
  rmswd_fifo #(
    .Width (JobW),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Compute the RMS level of each window
  rmswd_back #(
    .Points      (Points),
    .MaxChannels (MaxChannels),
    .JobW        (JobW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (pop_valid),
    .job_ready_o   (pop_ready),
    .job_i         (pop_data),
    .point_valid_o (out_o.valid),
    .point_ready_i (out_o.ready),
    .point_index_o (out_o.point_index),
    .rms_level_o   (out_o.rms_level),
    .last_point_o  (out_o.last_point)
  );

endmodule

### rtl/core/rmswd_checker.sv
// Port-level checks of the windowed RMS downsampler, bound to its top level.
// Depends on rmswd_pkg and rms_window_downsampler_unit.
module rmswd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [rmswd_pkg::PointIdxW-1:0] point_index_i,
  input logic [rmswd_pkg::LevelW-1:0]   rms_level_i,
  input logic                           last_point_i
);
  import rmswd_pkg::*;

  // Hold a stalled point
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("point dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(point_index_i) && $stable(rms_level_i) && $stable(last_point_i))
    else $error("point changed while stalled");

  // Level never exceeds full scale
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> rms_level_i <= MaxLevel)
    else $error("rms level above full scale");

  // A configuration write reloads the bounds before the next sample
  a_cfg_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_i)
    else $error("sample accepted during bound reload");

  // Back end never delivers points back to back
  a_point_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i |=> !out_valid_i)
    else $error("points delivered back to back");

endmodule

bind rms_window_downsampler_unit rmswd_checker u_rmswd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .point_index_i (out_o.point_index),
  .rms_level_i   (out_o.rms_level),
  .last_point_i  (out_o.last_point)
);

### bench/tb_top.sv
// Self-checking bench for rms_window_downsampler_unit: random paced sample stream in,
// display points checked field by field against an in-bench window RMS predictor.
// Depends on rmswd_pkg, rmswd_if and the RTL of the downsampler.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rmswd_pkg::*;

  localparam int unsigned Points     = DefaultPoints;
  localparam int unsigned DrainWait  = 60;
  localparam int unsigned CycleLimit = 2_000_000;  // slowest legal run is well under this
  localparam int unsigned PrintCap   = 40;

  typedef struct packed {
    logic [PointIdxW-1:0] index;
    logic [LevelW-1:0]    level;
    logic                 last;
  } point_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;

  rmswd_sample_if in_if ();
  rmswd_point_if  out_if ();

  rms_window_downsampler_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_addr_i (cfg_addr),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic signed [SampleW-1:0] sample_backlog[$];
  point_t                    points_due[$];

  int unsigned cycles      = 0;
  int unsigned errors      = 0;
  int unsigned samples_fed = 0;
  int unsigned points_seen = 0;
  int unsigned reg_writes  = 0;

  // Pacing: percent chance per free cycle to start an idle burst
  int unsigned send_odds = 0;
  int unsigned recv_odds = 0;
  int unsigned send_gap  = 0;
  int unsigned hold_gap  = 0;
  bit          word_taken = 1'b0;

  // Predictor state and its copy of the registers
  logic [FrameCountW-1:0] frames_reg;
  logic [ChanCountW-1:0]  chans_reg;
  int unsigned            frame_pos;
  int unsigned            chan_pos;
  int unsigned            win_num;
  longint unsigned        win_end;
  longint unsigned        sq_sum;
  longint unsigned        tally;

  function automatic longint unsigned frames_used();
    longint unsigned n;
    n = frames_reg;
    if (n < Points) n = Points;
    if (n > MaxFrames) n = MaxFrames;
    return n;
  endfunction

  function automatic int unsigned chans_used();
    int unsigned c;
    c = chans_reg;
    if (c == 0) c = 1;
    if (c > DefaultMaxChannels) c = DefaultMaxChannels;
    return c;
  endfunction

  // First frame past window w, exact integer split of the buffer
  function automatic longint unsigned window_end(int unsigned w);
    return ((longint'(w) + 1) * frames_used()) / Points;
  endfunction

  // Bit-pair square root, floor
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned pair;
    longint unsigned rem;
    root = 0;
    rem  = v;
    pair = 64'h4000_0000_0000_0000;
    while (pair > rem) pair >>= 2;
    while (pair != 0) begin
      if (rem >= root + pair) begin
        rem  -= root + pair;
        root  = (root >> 1) + pair;
      end else begin
        root >>= 1;
      end
      pair >>= 2;
    end
    return root;
  endfunction

  task automatic restart_buffer();
    frame_pos = 0;
    chan_pos  = 0;
    win_num   = 0;
    sq_sum    = 0;
    tally     = 0;
    win_end   = window_end(0);
  endtask

  task automatic apply_reg_write(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    case (idx)
      REG_FRAME_COUNT:   frames_reg = val[FrameCountW-1:0];
      REG_CHANNEL_COUNT: chans_reg  = val[ChanCountW-1:0];
      default: return;
    endcase
    restart_buffer();
  endtask

  // Accumulate one sample; queue a point when it closes a window
  task automatic predict_sample(logic signed [SampleW-1:0] s);
    longint unsigned mag;
    point_t          p;
    mag = (s < 0) ? longint'(-int'(s)) : longint'(int'(s));
    sq_sum += mag * mag;
    tally++;
    chan_pos++;
    if (chan_pos < chans_used()) return;
    chan_pos = 0;
    frame_pos++;
    if (frame_pos < win_end) return;
    p.index = win_num[PointIdxW-1:0];
    p.level = LevelW'(floor_sqrt(sq_sum / tally));
    p.last  = (win_num >= Points - 1);
    points_due.push_back(p);
    sq_sum = 0;
    tally  = 0;
    if (p.last) begin
      frame_pos = 0;
      win_num   = 0;
    end else begin
      win_num++;
    end
    win_end = window_end(win_num);
  endtask

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    errors++;
    if (errors <= PrintCap)
      $display("mismatch in %s: got %0d, want %0d (cycle %0d)", what, got, want, cycles);
  endtask

  // Feed sample words from the backlog, with random idle bursts
  always @(negedge clk_i) begin : feed_samples
    logic nv;
    nv = in_if.valid;
    if (!rst_ni) begin
      nv = 1'b0;
    end else begin
      if (word_taken) begin
        nv         = 1'b0;
        word_taken = 1'b0;
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (sample_backlog.size() > 0) begin
          if (send_odds != 0 && $urandom_range(99, 0) < send_odds) begin
            send_gap = $urandom_range(17, 1) - 1;
          end else begin
            nv = 1'b1;
            in_if.sample <= sample_backlog.pop_front();
          end
        end
      end
    end
    in_if.valid <= nv;
  end

  // Predict on every accepted sample word
  always @(posedge clk_i) begin : take_samples
    if (rst_ni && in_if.valid && in_if.ready) begin
      predict_sample(in_if.sample);
      word_taken = 1'b1;
      samples_fed++;
    end
  end

  // Stall the point channel in random bursts
  always @(negedge clk_i) begin : pace_points
    logic nr;
    nr = 1'b1;
    if (hold_gap > 0) begin
      hold_gap--;
      nr = 1'b0;
    end else if (recv_odds != 0 && $urandom_range(99, 0) < recv_odds) begin
      hold_gap = $urandom_range(17, 1) - 1;
      nr       = 1'b0;
    end
    out_if.ready <= nr;
  end

  // Compare each accepted point word with the oldest prediction
  always @(posedge clk_i) begin : check_points
    point_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      points_seen++;
      if (points_due.size() == 0) begin
        report_mismatch("unexpected point, index", out_if.point_index, 0);
      end else begin
        want = points_due.pop_front();
        if (out_if.point_index !== want.index)
          report_mismatch("point_index", out_if.point_index, want.index);
        if (out_if.rms_level !== want.level)
          report_mismatch("rms_level", out_if.rms_level, want.level);
        if (out_if.last_point !== want.last)
          report_mismatch("last_point", out_if.last_point, want.last);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int unsigned pace_odds();
    case ($urandom_range(3, 0))
      0:       return 0;
      1:       return 4;
      2:       return 12;
      default: return 30;
    endcase
  endfunction

  task automatic queue_samples(int unsigned count);
    logic signed [SampleW-1:0] s;
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(7, 0))
        0:       s = 16'h8000;
        1:       s = 16'h7FFF;
        2:       s = $urandom_range(1, 0) ? 16'h0000 : 16'hFFFF;
        default: s = SampleW'($urandom);
      endcase
      sample_backlog.push_back(s);
    end
  endtask

  // Wait for the stream to drain and every point to arrive, then let the back end settle
  task automatic drain();
    @(posedge clk_i);
    while (sample_backlog.size() != 0 || in_if.valid || points_due.size() != 0)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    apply_reg_write(idx, val);
    reg_writes++;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    in_if.valid  = 1'b0;
    in_if.sample = '0;
    out_if.ready = 1'b0;
    cfg_we       = 1'b0;
    cfg_addr     = REG_FRAME_COUNT;
    cfg_wdata    = '0;
    frames_reg   = FrameCountReset;
    chans_reg    = ChanCountReset;
    restart_buffer();

    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: one sample per window, level equals |sample|
    send_odds = 10;
    recv_odds = 10;
    sample_backlog.push_back(16'h0000);
    sample_backlog.push_back(16'h7FFF);
    sample_backlog.push_back(16'h8000);
    sample_backlog.push_back(16'hFFFF);
    sample_backlog.push_back(16'h0001);
    sample_backlog.push_back(16'h8001);
    sample_backlog.push_back(16'h5555);
    sample_backlog.push_back(16'hAAAA);
    drain();

    // Finish the buffer: crosses the last point and the wrap into the next one,
    // with one pause until every point is back
    send_odds = pace_odds();
    recv_odds = pace_odds();
    queue_samples(248);
    drain();
    send_odds = pace_odds();
    recv_odds = pace_odds();
    queue_samples(257);
    drain();

    // Zero channel count runs as one channel
    send_odds = 10;
    recv_odds = 10;
    write_reg(REG_CHANNEL_COUNT, '0);
    sample_backlog.push_back(16'sd100);
    sample_backlog.push_back(-16'sd100);
    drain();

    // Oversized channel count clamps to the maximum, frame count zero to the minimum
    write_reg(REG_CHANNEL_COUNT, CfgDataW'(4'hF));
    write_reg(REG_FRAME_COUNT, '0);
    // Partial window, then drop it with a register write
    repeat (3) sample_backlog.push_back(16'h7FFF);
    drain();
    write_reg(REG_CHANNEL_COUNT, CfgDataW'(DefaultMaxChannels));
    repeat (7) sample_backlog.push_back(16'h8000);
    sample_backlog.push_back(16'h7FFF);
    drain();

    // Oversized frame count clamps to the maximum; a few samples close no window
    write_reg(REG_FRAME_COUNT, '1);
    write_reg(REG_CHANNEL_COUNT, CfgDataW'(1));
    repeat (4) sample_backlog.push_back(16'h8000);
    drain();

    // Random small settings; the last round runs with no idling
    for (int r = 0; r < 2; r++) begin
      send_odds = (r == 0) ? pace_odds() : 0;
      recv_odds = (r == 0) ? pace_odds() : 0;
      write_reg(REG_FRAME_COUNT, CfgDataW'($urandom_range(1500, 0)));
      write_reg(REG_CHANNEL_COUNT, CfgDataW'($urandom));
      queue_samples(10);
      drain();
    end

    $display("run covered %0d samples, %0d points, %0d register writes", samples_fed,
             points_seen, reg_writes);
    $display("cases: clamped counts, abandoned windows, last point and wrap, random settings");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
